[hw/rtl/sliding_window_rate_meter_top_macros.svh]
// Assertion macros for the sliding window rate meter.
// Used by the port checker; no other dependencies.
`ifndef SLIDING_WINDOW_RATE_METER_TOP_MACROS_SVH
`define SLIDING_WINDOW_RATE_METER_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SWRM_ASSERT_IMPL(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication checked outside reset.
`define SWRM_ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

[hw/rtl/swrm_pkg.sv]
// Shared types and constants for the sliding window rate meter.
// No dependencies.
`timescale 1ns / 1ps
package swrm_pkg;
   localparam int unsigned DATA_W = 32;
   localparam logic [31:0] MS_PER_SEC = 32'd1000;
   localparam logic [31:0] WINDOW_RESET = 32'd10000;
   localparam logic [31:0] GAP_RESET = 32'd1000;
   localparam logic [31:0] WARMUP_RESET = 32'd2000;
   localparam logic [1:0] CSR_WINDOW = 2'd0;
   localparam logic [1:0] CSR_GAP = 2'd1;
   localparam logic [1:0] CSR_WARMUP = 2'd2;

   // One classified measurement moving from the front to the back.
   typedef struct packed {
      logic [31:0] now_ms;
      logic [31:0] sent_bytes;
      logic        restart;
      logic        warm;
   } cmd_type;

   // One finished result.
   typedef struct packed {
      logic [31:0] rate_bps;
      logic [31:0] window_bytes;
   } res_type;
endpackage

[hw/rtl/swrm_front.sv]
// Front end: accepts items, compares the upload age against warm-up, queues commands.
// Depends on swrm_pkg.
`timescale 1ns / 1ps
module swrm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [31:0]       now_ms,
   input  logic [31:0]       sent_bytes,
   input  logic [31:0]       upload_age_ms,
   input  logic              restart,
   input  logic [31:0]       warmup_ms,
   output logic              cmd_valid,
   input  logic              cmd_take,
   output swrm_pkg::cmd_type cmd
);
   import swrm_pkg::*;
   // Two-entry command queue.
   cmd_type     q_ff [2];
   logic [1:0]  cnt_ff, cnt_in;
   logic        wr_ff, wr_in, rd_ff, rd_in;
   logic        do_push;
   cmd_type     c;

   assign full = cnt_ff[1];
   assign do_push = push && !full;
   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd = q_ff[rd_ff];

   always_comb begin
      c.now_ms = now_ms;
      c.sent_bytes = sent_bytes;
      c.restart = restart;
      c.warm = upload_age_ms > warmup_ms;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, cmd_take};
      wr_in = wr_ff ^ do_push;
      rd_in = rd_ff ^ cmd_take;
   end

   // Hold queue pointers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end

   // Write entry.
   always_ff @(posedge clock) begin
      if (do_push) q_ff[wr_ff] <= c;
   end
endmodule

[hw/rtl/swrm_div.sv]
// Restoring serial divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on swrm_pkg.
`timescale 1ns / 1ps
module swrm_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   import swrm_pkg::*;
   logic [63:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] d_ff, d_in;
   logic [6:0]  n_ff, n_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] sh;

   assign done = done_ff;
   assign quotient = q_ff;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; n_in = n_ff;
      busy_in = busy_ff; done_in = 1'b0;
      sh = {r_ff[31:0], q_ff[63]};
      if (start) begin
         q_in = dividend; r_in = '0; d_in = divisor; n_in = 7'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         // Shift in one dividend bit; subtract when it fits.
         if (sh >= {1'b0, d_ff}) begin
            r_in = sh - {1'b0, d_ff};
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = sh;
            q_in = {q_ff[62:0], 1'b0};
         end
         n_in = n_ff + 7'd1;
         if (n_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; n_ff <= n_in;
   end
endmodule

[hw/rtl/swrm_back.sv]
// Back end: ring update, eviction walk, rate division and result register.
// Depends on swrm_pkg and swrm_div.
`timescale 1ns / 1ps
module swrm_back #(
   parameter int unsigned RING_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_take,
   input  swrm_pkg::cmd_type cmd,
   input  logic [31:0]       window_ms,
   input  logic [31:0]       min_gap_ms,
   output logic              res_valid,
   input  logic              res_take,
   output swrm_pkg::res_type res
);
   import swrm_pkg::*;
   localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int unsigned CW = $clog2(RING_DEPTH + 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(RING_DEPTH);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_RDNEW  = 8'b0000_0010,
      S_APPEND = 8'b0000_0100,
      S_RDOLD  = 8'b0000_1000,
      S_EVICT  = 8'b0001_0000,
      S_DIV    = 8'b0010_0000,
      S_WAIT   = 8'b0100_0000,
      S_OUT    = 8'b1000_0000
   } state_type;

   state_type   st_ff, st_in;
   logic [31:0] bytes_mem [RING_DEPTH];
   logic [31:0] time_mem [RING_DEPTH];
   logic [31:0] rb_ff, rt_ff;
   logic [AW-1:0] oldest_ff, oldest_in, raddr;
   logic [CW-1:0] count_ff, count_in;
   logic [63:0] sum_ff, sum_in;
   cmd_type     c_ff, c_in;
   logic        we;
   logic [AW-1:0] waddr;
   logic        full_drop;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] span;
   logic        div_start, div_done;
   logic [63:0] quo;
   logic [31:0] rate_ff, rate_in;
   res_type     r_ff, r_in;
   logic        rv_ff, rv_in;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
      logic [CW:0] s;
      s = {{(CW+1-AW){1'b0}}, a} + {1'b0, b};
      if (s >= (CW+1)'(RING_DEPTH)) s = s - (CW+1)'(RING_DEPTH);
      return s[AW-1:0];
   endfunction

   function automatic logic [31:0] sat32(input logic [63:0] v);
      return (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   assign cmd_take = (st_ff == S_IDLE) && cmd_valid;
   assign res_valid = rv_ff;
   assign res = r_ff;
   assign full_drop = count_ff == FULL_CNT;
   assign span = c_ff.now_ms - rt_ff;

   // Sequence one command.
   always_comb begin
      st_in = st_ff; oldest_in = oldest_ff; count_in = count_ff; sum_in = sum_ff;
      c_in = c_ff; we = 1'b0; waddr = wrap_add(oldest_ff, count_ff);
      raddr = oldest_ff; prod_in = prod_ff; div_start = 1'b0;
      rate_in = rate_ff;
      r_in = r_ff; rv_in = rv_ff && !res_take;
      unique case (st_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               c_in = cmd;
               if (cmd.restart) begin
                  oldest_in = '0; count_in = '0; sum_in = '0;
               end
               st_in = S_RDNEW;
            end
         end
         S_RDNEW: begin
            // Read newest time; the bytes port always reads the oldest entry.
            raddr = wrap_add(oldest_ff, count_ff - CW'(1));
            st_in = S_APPEND;
         end
         S_APPEND: begin
            if (c_ff.sent_bytes != 32'd0 || count_ff == '0 ||
                c_ff.now_ms >= rt_ff + min_gap_ms) begin
               if (full_drop) begin
                  // Drop oldest first; rb holds its bytes.
                  sum_in = sum_ff - {32'd0, rb_ff};
                  oldest_in = wrap_add(oldest_ff, CW'(1));
                  waddr = oldest_ff;
                  count_in = count_ff;
               end else begin
                  count_in = count_ff + CW'(1);
               end
               we = 1'b1;
               sum_in = sum_in + {32'd0, c_ff.sent_bytes};
            end
            st_in = S_RDOLD;
         end
         S_RDOLD: st_in = S_EVICT;
         S_EVICT: begin
            if (count_ff != '0 && c_ff.now_ms >= rt_ff + window_ms) begin
               sum_in = sum_ff - {32'd0, rb_ff};
               oldest_in = wrap_add(oldest_ff, CW'(1));
               count_in = count_ff - CW'(1);
               st_in = S_RDOLD;
            end else if (count_ff != '0 && c_ff.warm && c_ff.now_ms > rt_ff) begin
               // Scale by 1000 as 1024 - 16 - 8.
               prod_in = (sum_ff << 10) - (sum_ff << 4) - (sum_ff << 3);
               st_in = S_DIV;
            end else begin
               rate_in = '0;
               st_in = S_OUT;
            end
         end
         S_DIV: begin
            div_start = 1'b1;
            st_in = S_WAIT;
         end
         S_WAIT: begin
            if (div_done) begin
               rate_in = sat32(quo);
               st_in = S_OUT;
            end
         end
         S_OUT: begin
            // Hold until the result slot is free, then load it.
            if (!rv_ff || res_take) begin
               r_in.rate_bps = rate_ff;
               r_in.window_bytes = sat32(sum_ff);
               rv_in = 1'b1;
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         oldest_ff <= '0;
         count_ff <= '0;
         sum_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         oldest_ff <= oldest_in;
         count_ff <= count_in;
         sum_ff <= sum_in;
         rv_ff <= rv_in;
      end
      c_ff <= c_in;
      prod_ff <= prod_in;
      rate_ff <= rate_in;
      r_ff <= r_in;
   end

   // Ring memory, one write and registered reads of the oldest bytes and one time.
   always_ff @(posedge clock) begin
      if (we) begin
         bytes_mem[waddr] <= c_ff.sent_bytes;
         time_mem[waddr] <= c_ff.now_ms;
      end
      rb_ff <= bytes_mem[oldest_ff];
      rt_ff <= time_mem[raddr];
   end

   swrm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (span),
      .done     (div_done),
      .quotient (quo)
   );
endmodule

[hw/rtl/sliding_window_rate_meter_top.sv]
// Sliding window rate meter. One item at a time; each is appended, old samples are
// evicted, and when a rate is divided the serial divider works at one
// quotient bit per cycle, 64 steps.
// A two-entry command queue lets new items be taken while one is at work.
// Synchronous reset empties the ring and the sum and loads the register defaults.
// Depends on swrm_pkg, swrm_front, swrm_back.
`timescale 1ns / 1ps
module sliding_window_rate_meter_top #(
   parameter int unsigned RING_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [31:0] req_now_ms,
   input  logic [31:0] req_sent_bytes,
   input  logic [31:0] req_upload_age_ms,
   input  logic        req_restart,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_rate_bps,
   output logic [31:0] rsp_window_bytes,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import swrm_pkg::*;
   logic [31:0] window_ff, gap_ff, warmup_ff;
   logic        cmd_valid, cmd_take, res_valid;
   cmd_type     cmd;
   res_type     res;

   assign csr_ready = 1'b1;

   // Hold configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         gap_ff <= GAP_RESET;
         warmup_ff <= WARMUP_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW: window_ff <= csr_data;
            CSR_GAP:    gap_ff <= csr_data;
            CSR_WARMUP: warmup_ff <= csr_data;
            default: ;
         endcase
      end
   end

   swrm_front u_front (
      .clock, .reset, .push, .full,
      .now_ms        (req_now_ms),
      .sent_bytes    (req_sent_bytes),
      .upload_age_ms (req_upload_age_ms),
      .restart       (req_restart),
      .warmup_ms     (warmup_ff),
      .cmd_valid, .cmd_take, .cmd
   );

   swrm_back #(.RING_DEPTH(RING_DEPTH)) u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd,
      .window_ms  (window_ff),
      .min_gap_ms (gap_ff),
      .res_valid,
      .res_take   (pop && !empty),
      .res
   );

   assign empty = !res_valid;
   assign rsp_rate_bps = res.rate_bps;
   assign rsp_window_bytes = res.window_bytes;
endmodule

[hw/rtl/swrm_checker.sv]
// Port checker for the rate meter, bound to the top level.
// Depends on sliding_window_rate_meter_top_macros.svh.
`timescale 1ns / 1ps
`include "sliding_window_rate_meter_top_macros.svh"
module swrm_checker (
   input logic        clock,
   input logic        reset,
   input logic        full,
   input logic        empty,
   input logic        pop,
   input logic [31:0] rsp_rate_bps,
   input logic [31:0] rsp_window_bytes
);
   `SWRM_ASSERT_NEXT(a_hold_rsp, clock, reset, !empty && !pop, $stable(rsp_window_bytes) && $stable(rsp_rate_bps), "result changed while waiting")
   `SWRM_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, empty && !full, "queue not empty after reset")
   `SWRM_ASSERT_IMPL(a_rsp_known, clock, reset, !empty, !$isunknown({rsp_rate_bps, rsp_window_bytes}), "unknown result while waiting")
   `SWRM_ASSERT_IMPL(a_flags_known, clock, reset, 1'b1, !$isunknown({full, empty}), "unknown queue flags")
endmodule

bind sliding_window_rate_meter_top swrm_checker u_checker (
   .clock, .reset, .full, .empty, .pop, .rsp_rate_bps, .rsp_window_bytes
);

[tb/sv/testbench.sv]
// Testbench for the sliding window rate meter: directed table plus random calls,
// checked against an in-bench predictor of ring, sum and rate.
// Depends on swrm_pkg and sliding_window_rate_meter_top.
`timescale 1ns / 1ps
module testbench;
   import swrm_pkg::*;

   localparam int DEPTH = 64;
   localparam int LIMIT_CYCLES = 2000000;

   typedef struct {
      logic [31:0] now_ms;
      logic [31:0] sent_bytes;
      logic [31:0] upload_age_ms;
      logic        restart;
      logic        has_rate;
      logic [31:0] rate_bps;
      logic [31:0] window_bytes;
   } call_row_type;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [31:0] req_now_ms;
   logic [31:0] req_sent_bytes;
   logic [31:0] req_upload_age_ms;
   logic        req_restart;
   logic        empty;
   logic        pop;
   logic [31:0] rsp_rate_bps;
   logic [31:0] rsp_window_bytes;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   // predictor state
   logic [31:0] win_ms, gap_ms, warm_ms;
   logic [31:0] ring_bytes [DEPTH];
   logic [31:0] ring_time [DEPTH];
   int          head_idx;
   int          fill;
   logic [63:0] byte_sum;

   res_type     expected_rates [$];
   int          mismatches;
   int          results_seen;
   int          cycle_count;
   bit          rx_hold;
   bit          calm;
   logic [31:0] clock_ms;

   sliding_window_rate_meter_top #(.RING_DEPTH(DEPTH)) i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // drop the oldest sample from the predicted ring
   task automatic evict_oldest();
      byte_sum = byte_sum - ring_bytes[head_idx];
      head_idx = (head_idx + 1) % DEPTH;
      fill--;
   endtask

   function automatic logic [31:0] clip32(logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   // advance the predictor by one call and queue its result
   task automatic predict_rate(logic [31:0] now, logic [31:0] sent,
                               logic [31:0] age, logic rst_flag);
      bit          add;
      int          slot;
      logic [31:0] t0;
      logic [63:0] span;
      res_type     r;
      if (rst_flag) begin
         head_idx = 0;
         fill = 0;
         byte_sum = '0;
      end
      if (sent != 0 || fill == 0) begin
         add = 1;
      end else begin
         add = now >= 32'(ring_time[(head_idx + fill - 1) % DEPTH] + gap_ms);
      end
      if (add) begin
         if (fill >= DEPTH) evict_oldest();
         slot = (head_idx + fill) % DEPTH;
         ring_bytes[slot] = sent;
         ring_time[slot] = now;
         fill++;
         byte_sum = byte_sum + sent;
      end
      while (fill > 0 && now >= 32'(ring_time[head_idx] + win_ms)) evict_oldest();
      r.rate_bps = '0;
      if (fill > 0 && age > warm_ms) begin
         t0 = ring_time[head_idx];
         if (now > t0) begin
            span = 64'(now - t0);
            r.rate_bps = clip32((byte_sum * 64'd1000) / span);
         end
      end
      r.window_bytes = clip32(byte_sum);
      expected_rates.push_back(r);
   endtask

   // push stays high on return; drain or the next idle cycle drops it
   task automatic send_call(logic [31:0] now, logic [31:0] sent,
                            logic [31:0] age, logic rst_flag);
      while (!calm && $urandom_range(99) < 23) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_now_ms <= now;
      req_sent_bytes <= sent;
      req_upload_age_ms <= age;
      req_restart <= rst_flag;
      predict_rate(now, sent, age, rst_flag);
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_WINDOW: win_ms = val;
         CSR_GAP:    gap_ms = val;
         CSR_WARMUP: warm_ms = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain();
      push <= 1'b0;
      while (expected_rates.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // mostly well-paced calls with bursts, some restarts and raw noise
   task automatic random_call();
      logic [31:0] sent;
      logic [31:0] age;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         send_call($urandom, $urandom, $urandom, $urandom_range(1));
      end else begin
         clock_ms = clock_ms + $urandom_range(pick < 60 ? 400 : 3000);
         sent = ($urandom_range(3) == 0) ? 32'd0 : $urandom_range(pick < 20 ? 1 : 200000);
         if (pick > 95) sent = $urandom;
         age = $urandom_range(5000);
         send_call(clock_ms, sent, age, pick == 50);
      end
   endtask

   // receiver: random pops, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         pop <= !rx_hold && (calm || $urandom_range(99) >= 23);
      end
   end

   // check each accepted result against the oldest expectation
   always @(posedge clock) begin
      res_type want;
      if (!reset && pop && !empty) begin
         results_seen++;
         if (expected_rates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item rate=%0d bytes=%0d",
                                           rsp_rate_bps, rsp_window_bytes);
         end else begin
            want = expected_rates.pop_front();
            if (want.rate_bps !== rsp_rate_bps || want.window_bytes !== rsp_window_bytes) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: rate exp %0d got %0d, bytes exp %0d got %0d",
                           want.rate_bps, rsp_rate_bps, want.window_bytes, rsp_window_bytes);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   call_row_type directed [14] = '{
      // empty ring, young upload: no rate
      '{32'd1000, 32'd0, 32'd0, 1'b0, 1'b1, 32'd0, 32'd0},
      '{32'd2000, 32'd500, 32'd1000, 1'b0, 1'b1, 32'd0, 32'd500},
      '{32'd3000, 32'd500, 32'd3000, 1'b0, 1'b0, 32'd0, 32'd0},
      '{32'd3000, 32'd0, 32'd3000, 1'b0, 1'b0, 32'd0, 32'd0},
      '{32'd3500, 32'd0, 32'd3000, 1'b0, 1'b0, 32'd0, 32'd0},
      '{32'd4000, 32'd0, 32'd3000, 1'b0, 1'b0, 32'd0, 32'd0},
      // restart with data in the same call
      '{32'd5000, 32'd700, 32'd9000, 1'b1, 1'b1, 32'd0, 32'd700},
      '{32'd20000, 32'd0, 32'd9000, 1'b0, 1'b0, 32'd0, 32'd0},
      // extremes of the fields
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0, 32'd0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0, 32'd0},
      '{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0, 32'd0},
      '{32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0, 32'd0},
      '{32'd2, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0},
      '{32'hAAAA_5555, 32'h5555_AAAA, 32'h5555_AAAA, 1'b1, 1'b0, 32'd0, 32'd0}
   };

   initial begin
      int n;
      reset = 1'b1;
      push = 1'b0;
      req_now_ms = '0;
      req_sent_bytes = '0;
      req_upload_age_ms = '0;
      req_restart = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_WINDOW;
      csr_data = '0;
      rx_hold = 0;
      calm = 0;
      mismatches = 0;
      results_seen = 0;
      cycle_count = 0;
      win_ms = WINDOW_RESET;
      gap_ms = GAP_RESET;
      warm_ms = WARMUP_RESET;
      head_idx = 0;
      fill = 0;
      byte_sum = '0;
      clock_ms = 32'd100;
      foreach (ring_bytes[i]) begin
         ring_bytes[i] = '0;
         ring_time[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table under reset defaults
      foreach (directed[i]) begin
         send_call(directed[i].now_ms, directed[i].sent_bytes,
                   directed[i].upload_age_ms, directed[i].restart);
         if (directed[i].has_rate) begin
            expected_rates[$].rate_bps = directed[i].rate_bps;
            expected_rates[$].window_bytes = directed[i].window_bytes;
         end
      end
      drain();

      // zero window, zero gap and warm-up extremes
      write_csr(CSR_WINDOW, 32'd0);
      write_csr(CSR_GAP, 32'd0);
      write_csr(CSR_WARMUP, 32'd0);
      for (int k = 0; k < 6; k++) send_call(32'(k * 10), 32'(k), 32'd1, 1'b0);
      drain();
      write_csr(CSR_WINDOW, 32'hFFFF_FFFF);
      write_csr(CSR_WARMUP, 32'hFFFF_FFFF);
      send_call(32'd5, 32'd9, 32'hFFFF_FFFF, 1'b0);
      drain();

      // long receiver hold-off while the sender keeps pushing
      write_csr(CSR_WINDOW, 32'd1);
      write_csr(CSR_WARMUP, 32'd0);
      rx_hold = 1;
      fork
         begin
            repeat (400) @(posedge clock);
            rx_hold = 0;
         end
         for (int k = 0; k < 12; k++) send_call(32'(k * 3), 32'd77, 32'd5, 1'b0);
      join
      drain();

      // random phases across several register settings
      n = 0;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_WINDOW, WINDOW_RESET);
               write_csr(CSR_GAP, GAP_RESET);
               write_csr(CSR_WARMUP, WARMUP_RESET);
            end
            1: begin
               write_csr(CSR_WINDOW, 32'd200000);
               write_csr(CSR_GAP, 32'hFFFF_FFFF);
               write_csr(CSR_WARMUP, 32'd0);
            end
            2: write_csr(CSR_WINDOW, 32'd1);
            3: begin
               write_csr(CSR_WINDOW, $urandom_range(30000, 1));
               write_csr(CSR_GAP, $urandom_range(2000));
               write_csr(CSR_WARMUP, $urandom_range(4000));
            end
            default: write_csr(CSR_WINDOW, 32'hFFFF_FFFF);
         endcase
         calm = (phase == 2);
         for (int k = 0; k < 320; k++) begin
            random_call();
            n++;
         end
         drain();
      end
      calm = 0;

      $display("run covered %0d random calls plus directed rows, %0d results checked",
               n, results_seen);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb: failure");
      end
      $finish;
   end
endmodule
